// File: hdl/lfrs_pkg.sv
// Shared types and constants for the LED flash/ramp sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lfrs_pkg;

  // Command codes carried in a request
  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_RAMP  = 2'd1;
  localparam logic [1:0] CMD_FLASH = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_INVERT      = 3'd0;
  localparam logic [2:0] REG_ON_TIME     = 3'd1;
  localparam logic [2:0] REG_OFF_TIME    = 3'd2;
  localparam logic [2:0] REG_PAUSE_TIME  = 3'd3;
  localparam logic [2:0] REG_PULSE_COUNT = 3'd4;
  localparam logic [2:0] REG_START_DELAY = 3'd5;
  localparam logic [2:0] REG_ON_LEVEL    = 3'd6;
  localparam logic [2:0] REG_OFF_LEVEL   = 3'd7;

  localparam logic [7:0] FULL_LEVEL = 8'd255;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  target_level;
    logic [15:0] up_step_us;
    logic [15:0] down_step_us;
    logic [31:0] now_us;
    logic [31:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       on_phase;
  } out_rsp_t;

  typedef struct packed {
    logic        invert_output;
    logic [31:0] on_time_ms;
    logic [31:0] off_time_ms;
    logic [31:0] pause_time_ms;
    logic [7:0]  pulse_count;
    logic [31:0] start_delay_ms;
    logic [7:0]  flash_on_level;
    logic [7:0]  flash_off_level;
  } cfg_regs_t;

  // Flash pattern status after this request's update
  typedef struct packed {
    logic [7:0] target;
    logic       start_flag;
  } flash_stat_t;

endpackage

`default_nettype wire

// File: hdl/lfrs_flash.sv
// Flash pattern phase machine: start delay, on, off, pulse count, pause.
`timescale 1ns / 1ps
`default_nettype none

module lfrs_flash (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,      // accepted flash request
  input  wire logic                 restart,   // accepted set or ramp request
  input  wire logic [31:0]          now_ms,
  input  wire lfrs_pkg::cfg_regs_t  cfg,
  output lfrs_pkg::flash_stat_t     stat
);

  typedef enum logic [2:0] {
    PH_RESET,
    PH_DELAY,
    PH_ON_START,
    PH_ON_WAIT,
    PH_OFF_START,
    PH_OFF_WAIT,
    PH_GROUP_END,
    PH_PAUSE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cycles_r, cycles_nxt;
  logic [31:0] start_ms_r, start_ms_nxt;
  logic [7:0]  target_r, target_nxt;
  logic        flag_r, flag_nxt;

  logic [31:0] elapsed;
  logic [31:0] wait_ms;
  logic        expired;

  assign elapsed = now_ms - start_ms_r;

  // One compare serves all four timed phases
  always_comb begin
    unique case (phase_r)
      PH_DELAY:    wait_ms = cfg.start_delay_ms;
      PH_ON_WAIT:  wait_ms = cfg.on_time_ms;
      PH_OFF_WAIT: wait_ms = cfg.off_time_ms;
      PH_PAUSE:    wait_ms = cfg.pause_time_ms;
      default:     wait_ms = '0;
    endcase
  end

  assign expired = (elapsed >= wait_ms);

  always_comb begin
    phase_nxt    = phase_r;
    cycles_nxt   = cycles_r;
    start_ms_nxt = start_ms_r;
    target_nxt   = target_r;
    flag_nxt     = flag_r;
    if (restart) begin
      phase_nxt  = PH_RESET;
      cycles_nxt = '0;
    end else if (step) begin
      unique case (phase_r)
        PH_RESET: begin
          start_ms_nxt = now_ms;
          phase_nxt    = PH_DELAY;
        end
        PH_DELAY: begin
          if (expired) phase_nxt = PH_ON_START;
        end
        PH_ON_START: begin
          cycles_nxt   = cycles_r + 8'd1;
          start_ms_nxt = now_ms;
          phase_nxt    = PH_ON_WAIT;
          target_nxt   = cfg.flash_on_level;
          flag_nxt     = 1'b1;
        end
        PH_ON_WAIT: begin
          if (expired) begin
            phase_nxt = PH_OFF_START;
            flag_nxt  = 1'b0;
          end
        end
        PH_OFF_START: begin
          start_ms_nxt = now_ms;
          phase_nxt    = PH_OFF_WAIT;
          target_nxt   = cfg.flash_off_level;
        end
        PH_OFF_WAIT: begin
          if (expired) begin
            phase_nxt = PH_GROUP_END;
            flag_nxt  = 1'b0;
          end
        end
        PH_GROUP_END: begin
          // pulse count of zero acts as one
          if (cycles_r >= cfg.pulse_count) begin
            cycles_nxt   = '0;
            start_ms_nxt = now_ms;
            phase_nxt    = PH_PAUSE;
          end else begin
            phase_nxt = PH_ON_START;
          end
        end
        PH_PAUSE: begin
          if (expired) phase_nxt = PH_ON_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_RESET;
      cycles_r   <= '0;
      start_ms_r <= '0;
      target_r   <= '0;
      flag_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cycles_r   <= cycles_nxt;
      start_ms_r <= start_ms_nxt;
      target_r   <= target_nxt;
      flag_r     <= flag_nxt;
    end
  end

  assign stat.target     = target_nxt;
  assign stat.start_flag = flag_nxt;

endmodule

`default_nettype wire

// File: hdl/led_flash_ramp_sequencer_core.sv
// Top level of the LED flash/ramp sequencer: brightness ramp, flash pattern, duty output.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                         Handshake     Content
// in        in_valid/in_ready/in_req      valid/ready   command, target, step times, times
// out       out_valid/out_ready/out_rsp   valid/ready   duty, on_phase
// cfg       cfg_wr_en/cfg_index/cfg_wdata write enable  register index 0..7, 32-bit data
//
// One request per cycle while in_ready is high; each yields one registered response.
// The request's whole update (flash phase step, then one ramp step) settles in the
// cycle it is accepted; brightness and flash state are the loop that sets this rate.
// A held response does not block a new request while out_ready is high.
// Reset (rst_n low, synchronous) clears state and config; flash_on_level resets to 255.

module led_flash_ramp_sequencer_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lfrs_pkg::in_req_t  in_req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lfrs_pkg::out_rsp_t      out_rsp,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);

  lfrs_pkg::cfg_regs_t   cfg_r;
  lfrs_pkg::flash_stat_t flash_stat;
  lfrs_pkg::out_rsp_t    rsp_r, rsp_nxt;

  logic        out_valid_r;
  logic [7:0]  level_r, level_nxt;
  logic [31:0] last_us_r, last_us_nxt;

  logic        accept;
  logic        is_set, is_ramp, is_flash;
  logic [7:0]  ramp_tgt;
  logic        going_down;
  logic [15:0] step_us;
  logic [31:0] since_step;
  logic        step_due;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_set   = (in_req.command == lfrs_pkg::CMD_SET);
  assign is_ramp  = (in_req.command == lfrs_pkg::CMD_RAMP);
  assign is_flash = (in_req.command == lfrs_pkg::CMD_FLASH);

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_output   <= 1'b0;
      cfg_r.on_time_ms      <= '0;
      cfg_r.off_time_ms     <= '0;
      cfg_r.pause_time_ms   <= '0;
      cfg_r.pulse_count     <= '0;
      cfg_r.start_delay_ms  <= '0;
      cfg_r.flash_on_level  <= lfrs_pkg::FULL_LEVEL;
      cfg_r.flash_off_level <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lfrs_pkg::REG_INVERT:      cfg_r.invert_output   <= cfg_wdata[0];
        lfrs_pkg::REG_ON_TIME:     cfg_r.on_time_ms      <= cfg_wdata;
        lfrs_pkg::REG_OFF_TIME:    cfg_r.off_time_ms     <= cfg_wdata;
        lfrs_pkg::REG_PAUSE_TIME:  cfg_r.pause_time_ms   <= cfg_wdata;
        lfrs_pkg::REG_PULSE_COUNT: cfg_r.pulse_count     <= cfg_wdata[7:0];
        lfrs_pkg::REG_START_DELAY: cfg_r.start_delay_ms  <= cfg_wdata;
        lfrs_pkg::REG_ON_LEVEL:    cfg_r.flash_on_level  <= cfg_wdata[7:0];
        lfrs_pkg::REG_OFF_LEVEL:   cfg_r.flash_off_level <= cfg_wdata[7:0];
      endcase
    end
  end

  // Flash pattern; its updated target feeds this request's ramp step
  lfrs_flash u_flash (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept && is_flash),
    .restart (accept && (is_set || is_ramp)),
    .now_ms  (in_req.now_ms),
    .cfg     (cfg_r),
    .stat    (flash_stat)
  );

  // Ramp: at most one step per request toward the flash or request target; zero step time jumps
  assign ramp_tgt   = is_flash ? flash_stat.target : in_req.target_level;
  assign going_down = (level_r > ramp_tgt);
  assign step_us    = going_down ? in_req.down_step_us : in_req.up_step_us;
  assign since_step = in_req.now_us - last_us_r;
  assign step_due   = (since_step >= {16'd0, step_us});

  always_comb begin
    level_nxt   = level_r;
    last_us_nxt = last_us_r;
    if (is_set) begin
      level_nxt   = in_req.target_level;
      last_us_nxt = in_req.now_us;
    end else if (is_ramp || is_flash) begin
      if (level_r == ramp_tgt) begin
        last_us_nxt = in_req.now_us;
      end else if (step_us == 16'd0) begin
        level_nxt = ramp_tgt;             // zero step time jumps straight there
      end else if (step_due) begin
        last_us_nxt = in_req.now_us;
        level_nxt   = going_down ? (level_r - 8'd1) : (level_r + 8'd1);
      end
    end
  end

  // 255 - level is the bitwise complement for 8 bits
  always_comb begin
    rsp_nxt.duty     = cfg_r.invert_output ? ~level_nxt : level_nxt;
    rsp_nxt.on_phase = is_flash && flash_stat.start_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      last_us_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        level_r     <= level_nxt;
        last_us_r   <= last_us_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Response payload, loaded on acceptance
  always_ff @(posedge clk) begin
    if (accept) rsp_r <= rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule

`default_nettype wire
